// ===== rtl/ray_triangle_intersection_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the ray-triangle block.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECTION_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECTION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray-triangle intersection package
// Types, register codes and constants shared by the block's modules.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int COORD_FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH         = 2;
	localparam int CFG_INDEX_W         = 8;
	localparam int CFG_DATA_W          = 48;
	localparam int PROD_W              = 54;
	localparam int QUO_W               = 31;
	localparam int WHOLE_W             = 15;
	localparam int FRAC_W              = 16;

	localparam logic [47:0] VERTEX_ONE_RST   = 48'd256;
	localparam logic [47:0] VERTEX_TWO_RST   = 48'd16777216;
	localparam logic [47:0] VERTEX_THREE_RST = 48'd1099511627776;
	localparam logic [15:0] EPSILON_RST      = 16'd1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VERTEX_ONE   = 8'd0,
		REG_VERTEX_TWO   = 8'd1,
		REG_VERTEX_THREE = 8'd2,
		REG_EPSILON      = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic signed [15:0] origin_z;
		logic signed [15:0] direction_x;
		logic signed [15:0] direction_y;
		logic signed [15:0] direction_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] distance;
	} result_t;

	// Classified item handed from the geometry front to the divider back.
	typedef struct packed {
		logic               hit;
		logic               neg;
		logic [PROD_W-1:0]  mag;
		logic [PROD_W-1:0]  den;
	} cls_t;

	typedef struct packed {
		logic               hit;
		logic               neg;
		logic               sat;
		logic [PROD_W:0]    rem;
		logic [PROD_W-1:0]  den;
		logic [QUO_W-1:0]   nb;
		logic [QUO_W-1:0]   quo;
	} div_t;

endpackage

// ===== rtl/rti_queue.sv =====
// ----------------------------------------------------------------------------
// Classified item queue
// Small FIFO between the geometry front and the divider back.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersection_defines.svh"

module rti_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rti_pkg::cls_t wdata,
	output logic          pop,
	output rti_pkg::cls_t rdata,
	output logic          full
);
	import rti_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	cls_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	// The back never stalls, so anything queued leaves the next cycle.
	assign pop   = (count_q != '0);
	assign full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	`RTI_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full, "queue overflow")
	`RTI_ASSERT_NXT(a_drains, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1, "queue did not drain")

endmodule

// ===== rtl/rti_front.sv =====
// ----------------------------------------------------------------------------
// Geometry front
// Cross and dot products of the ray against the triangle, then the parallel
// and barycentric tests; emits one classified item per accepted ray.
// ----------------------------------------------------------------------------
module rti_front #(
	parameter int COORD_FRAC_BITS = rti_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  rti_pkg::ray_t ray,
	input  logic [47:0]   vertex_one,
	input  logic [47:0]   vertex_two,
	input  logic [47:0]   vertex_three,
	input  logic [15:0]   epsilon,
	output logic          push,
	output rti_pkg::cls_t item
);
	import rti_pkg::*;

	localparam int THR_SH = 2 * COORD_FRAC_BITS;

	logic signed [15:0] v1x, v1y, v1z, v2x, v2y, v2z, v3x, v3y, v3z;
	logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
	logic signed [16:0] sx, sy, sz;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	ray_t               ray_s1;
	logic signed [15:0] dx_s2, dy_s2, dz_s2, dx_s3, dy_s3, dz_s3;
	logic signed [16:0] sx_s2, sy_s2, sz_s2, sx_s3, sy_s3, sz_s3;
	logic signed [32:0] hp_s2 [6];
	logic signed [33:0] qp_s2 [6];
	logic signed [33:0] hx_s3, hy_s3, hz_s3;
	logic signed [34:0] qx_s3, qy_s3, qz_s3;
	logic signed [51:0] dp_s4 [3];
	logic signed [51:0] up_s4 [3];
	logic signed [51:0] vp_s4 [3];
	logic signed [51:0] tp_s4 [3];
	logic signed [53:0] det_s5, u_s5, v_s5n, t_s5;

	logic               det_neg;
	logic [53:0]        det_abs;
	logic [53:0]        thresh;
	logic               parallel;
	logic signed [55:0] un, vn, tn;
	logic               miss;

	assign v1x = vertex_one[15:0];   assign v1y = vertex_one[31:16];   assign v1z = vertex_one[47:32];
	assign v2x = vertex_two[15:0];   assign v2y = vertex_two[31:16];   assign v2z = vertex_two[47:32];
	assign v3x = vertex_three[15:0]; assign v3y = vertex_three[31:16]; assign v3z = vertex_three[47:32];

	// Edges follow the configuration, which the user must change only while idle; the block itself does not enforce it.
	assign e1x = 17'(v2x) - 17'(v1x);
	assign e1y = 17'(v2y) - 17'(v1y);
	assign e1z = 17'(v2z) - 17'(v1z);
	assign e2x = 17'(v3x) - 17'(v1x);
	assign e2y = 17'(v3y) - 17'(v1y);
	assign e2z = 17'(v3z) - 17'(v1z);

	assign sx = 17'(ray_s1.origin_x) - 17'(v1x);
	assign sy = 17'(ray_s1.origin_y) - 17'(v1y);
	assign sz = 17'(ray_s1.origin_z) - 17'(v1z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			push <= 1'b0;
		end else begin
			v_s1 <= accept; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			push <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		ray_s1 <= ray;
		// Partial products of h = dir x e2 and q = s x e1.
		dx_s2 <= ray_s1.direction_x; dy_s2 <= ray_s1.direction_y; dz_s2 <= ray_s1.direction_z;
		sx_s2 <= sx; sy_s2 <= sy; sz_s2 <= sz;
		hp_s2[0] <= ray_s1.direction_y * e2z; hp_s2[1] <= ray_s1.direction_z * e2y;
		hp_s2[2] <= ray_s1.direction_z * e2x; hp_s2[3] <= ray_s1.direction_x * e2z;
		hp_s2[4] <= ray_s1.direction_x * e2y; hp_s2[5] <= ray_s1.direction_y * e2x;
		qp_s2[0] <= sy * e1z; qp_s2[1] <= sz * e1y;
		qp_s2[2] <= sz * e1x; qp_s2[3] <= sx * e1z;
		qp_s2[4] <= sx * e1y; qp_s2[5] <= sy * e1x;
		// Cross products.
		dx_s3 <= dx_s2; dy_s3 <= dy_s2; dz_s3 <= dz_s2;
		sx_s3 <= sx_s2; sy_s3 <= sy_s2; sz_s3 <= sz_s2;
		hx_s3 <= 34'(hp_s2[0]) - 34'(hp_s2[1]);
		hy_s3 <= 34'(hp_s2[2]) - 34'(hp_s2[3]);
		hz_s3 <= 34'(hp_s2[4]) - 34'(hp_s2[5]);
		qx_s3 <= 35'(qp_s2[0]) - 35'(qp_s2[1]);
		qy_s3 <= 35'(qp_s2[2]) - 35'(qp_s2[3]);
		qz_s3 <= 35'(qp_s2[4]) - 35'(qp_s2[5]);
		// Terms of the four dot products.
		dp_s4[0] <= e1x * hx_s3; dp_s4[1] <= e1y * hy_s3; dp_s4[2] <= e1z * hz_s3;
		up_s4[0] <= sx_s3 * hx_s3; up_s4[1] <= sy_s3 * hy_s3; up_s4[2] <= sz_s3 * hz_s3;
		vp_s4[0] <= dx_s3 * qx_s3; vp_s4[1] <= dy_s3 * qy_s3; vp_s4[2] <= dz_s3 * qz_s3;
		tp_s4[0] <= e2x * qx_s3; tp_s4[1] <= e2y * qy_s3; tp_s4[2] <= e2z * qz_s3;
		det_s5 <= 54'(dp_s4[0]) + 54'(dp_s4[1]) + 54'(dp_s4[2]);
		u_s5   <= 54'(up_s4[0]) + 54'(up_s4[1]) + 54'(up_s4[2]);
		v_s5n  <= 54'(vp_s4[0]) + 54'(vp_s4[1]) + 54'(vp_s4[2]);
		t_s5   <= 54'(tp_s4[0]) + 54'(tp_s4[1]) + 54'(tp_s4[2]);
	end

	// Normalize signs so the determinant is positive, then test the region.
	always_comb begin
		det_neg  = det_s5[53];
		det_abs  = det_neg ? 54'(-det_s5) : 54'(det_s5);
		thresh   = 54'(epsilon) << THR_SH;
		parallel = (det_s5 == '0) || (det_abs < thresh);
		un       = det_neg ? -56'(u_s5) : 56'(u_s5);
		vn       = det_neg ? -56'(v_s5n) : 56'(v_s5n);
		tn       = det_neg ? -56'(t_s5) : 56'(t_s5);
		miss     = (un < 0) || (un > $signed({2'b00, det_abs})) || (vn < 0)
			|| ((un + vn) > $signed({2'b00, det_abs}));
	end

	always_ff @(posedge clk) begin
		item.hit <= !parallel && !miss;
		item.neg <= tn[55];
		item.mag <= tn[55] ? 54'(-tn) : 54'(tn);
		item.den <= det_abs;
	end

endmodule

// ===== rtl/rti_back.sv =====
// ----------------------------------------------------------------------------
// Distance divider
// Pipelined restoring division giving t in Q16.16, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rti_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  rti_pkg::cls_t    item,
	output logic             done,
	output rti_pkg::result_t result
);
	import rti_pkg::*;

	div_t              div_s [QUO_W+1];
	logic [QUO_W:0]     vld_s;
	logic [PROD_W+15:0] lim;
	logic [PROD_W:0]    trial [QUO_W];
	logic [QUO_W-1:0]   qfin;

	// Saturate when the whole part would not fit in 15 bits.
	assign lim = {1'b0, item.den, {WHOLE_W{1'b0}}};

	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			trial[k] = {div_s[k].rem[PROD_W-1:0], div_s[k].nb[QUO_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[QUO_W-1:0], take};
			done  <= vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		div_s[0].hit <= item.hit;
		div_s[0].neg <= item.neg;
		div_s[0].sat <= (PROD_W+16)'(item.mag) >= lim;
		div_s[0].rem <= (PROD_W+1)'(item.mag >> WHOLE_W);
		div_s[0].den <= item.den;
		div_s[0].nb  <= {item.mag[WHOLE_W-1:0], {FRAC_W{1'b0}}};
		div_s[0].quo <= '0;
		for (int k = 0; k < QUO_W; k++) begin
			div_s[k+1].hit <= div_s[k].hit;
			div_s[k+1].neg <= div_s[k].neg;
			div_s[k+1].sat <= div_s[k].sat;
			div_s[k+1].den <= div_s[k].den;
			div_s[k+1].nb  <= {div_s[k].nb[QUO_W-2:0], 1'b0};
			if (trial[k] >= {1'b0, div_s[k].den}) begin
				div_s[k+1].rem <= trial[k] - {1'b0, div_s[k].den};
				div_s[k+1].quo <= {div_s[k].quo[QUO_W-2:0], 1'b1};
			end else begin
				div_s[k+1].rem <= trial[k];
				div_s[k+1].quo <= {div_s[k].quo[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign qfin = div_s[QUO_W].quo;

	always_ff @(posedge clk) begin
		result.hit <= div_s[QUO_W].hit;
		if (!div_s[QUO_W].hit) begin
			result.distance <= '0;
		end else if (div_s[QUO_W].sat) begin
			result.distance <= div_s[QUO_W].neg ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			result.distance <= div_s[QUO_W].neg ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
		end
	end

endmodule

// ===== rtl/ray_triangle_intersection.sv =====
// ----------------------------------------------------------------------------
// Ray-triangle intersection
// Fixed-point Moller-Trumbore test of a stream of rays against one triangle.
// ----------------------------------------------------------------------------
// A ray is taken whenever start is high and busy is low, one ray every clock
// cycle. Each ray gives exactly one result, shown on result for a single
// cycle with done high. Between the two lie the ray register, the geometry
// front's stages (cross products, dot products, region tests), the queue and
// the divider, which has an input stage, a chain of 31 one-quotient-bit
// compare-and-subtract stages and the output register. Results leave in the
// order the rays came in, and the receiver cannot stall them; since the
// divider never stops, the queue never fills and busy stays low in normal
// use. The triangle vertices and the parallel threshold are written through
// the cfg channel, which is always ready; write them only while no ray is in
// flight.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersection_defines.svh"

module ray_triangle_intersection #(
	parameter int COORD_FRAC_BITS = rti_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  rti_pkg::ray_t                      ray,
	output logic                               done,
	output rti_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rti_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rti_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rti_pkg::*;

	logic [47:0] vertex_one_q, vertex_two_q, vertex_three_q;
	logic [15:0] epsilon_q;
	logic        accept;
	logic        push, pop;
	cls_t        wr_item, rd_item;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_one_q   <= VERTEX_ONE_RST;
			vertex_two_q   <= VERTEX_TWO_RST;
			vertex_three_q <= VERTEX_THREE_RST;
			epsilon_q      <= EPSILON_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERTEX_ONE:   vertex_one_q   <= cfg_data;
				REG_VERTEX_TWO:   vertex_two_q   <= cfg_data;
				REG_VERTEX_THREE: vertex_three_q <= cfg_data;
				REG_EPSILON:      epsilon_q      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// The front does all the geometry and decides hit or miss.
	rti_front #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.ray         (ray),
		.vertex_one  (vertex_one_q),
		.vertex_two  (vertex_two_q),
		.vertex_three(vertex_three_q),
		.epsilon     (epsilon_q),
		.push        (push),
		.item        (wr_item)
	);

	// The queue decouples the front from the divider.
	rti_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wr_item),
		.pop   (pop),
		.rdata (rd_item),
		.full  (busy)
	);

	// The back turns the normalized numerator and determinant into t.
	rti_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (pop),
		.item  (rd_item),
		.done  (done),
		.result(result)
	);

	`RTI_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !result.hit, result.distance == '0, "miss with nonzero distance")
	`RTI_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy, "queue filled up")

endmodule

// ===== bench/tb_ray_triangle_intersection.sv =====
// ----------------------------------------------------------------------------
// Ray-triangle intersection testbench
// Streams rays through the block under several triangle and threshold
// settings, predicts each result with an independent fixed-point Moller-
// Trumbore model and checks every result in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_triangle_intersection;
	import rti_pkg::*;

	localparam int FB        = COORD_FRAC_BITS_DEF;
	localparam int LATENCY   = 39;
	localparam int IDLE_MAX  = 5000;
	localparam int N_RANDOM  = 1200;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	ray_t                   ray;
	logic                   done;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Shadow copy of the configuration registers.
	logic [47:0] vert_a, vert_b, vert_c;
	logic [15:0] eps_reg;

	result_t expected_hits[$];
	int      fail_count;
	int      idle_cycles;

	ray_triangle_intersection DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ray(ray),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Quotient in Q16.16, truncated toward zero and saturated.
	function automatic logic [31:0] div_q16(longint num, longint den);
		logic   neg;
		longint mag, whole, rem, frac;
		logic [31:0] m;
		neg = num < 0;
		mag = neg ? -num : num;
		whole = mag / den;
		rem = mag % den;
		frac = 0;
		if (whole >= 32768)
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		for (int i = 0; i < 16; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= den) begin
				rem = rem - den;
				frac = frac | 1;
			end
		end
		m = 32'((whole << 16) | frac);
		return neg ? -m : m;
	endfunction

	function automatic longint coord(logic [47:0] p, int k);
		return longint'($signed(p[16*k +: 16]));
	endfunction

	// Intersection test of one ray against the shadow triangle.
	function automatic result_t predict_intersection(ray_t r);
		result_t res;
		longint o[3], d[3], e1[3], e2[3], s[3], h[3], q[3];
		longint det, uu, vv, tt, thr, adet;
		o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
		d[0] = r.direction_x; d[1] = r.direction_y; d[2] = r.direction_z;
		for (int k = 0; k < 3; k++) begin
			e1[k] = coord(vert_b, k) - coord(vert_a, k);
			e2[k] = coord(vert_c, k) - coord(vert_a, k);
			s[k]  = o[k] - coord(vert_a, k);
		end
		h[0] = d[1]*e2[2] - d[2]*e2[1];
		h[1] = d[2]*e2[0] - d[0]*e2[2];
		h[2] = d[0]*e2[1] - d[1]*e2[0];
		q[0] = s[1]*e1[2] - s[2]*e1[1];
		q[1] = s[2]*e1[0] - s[0]*e1[2];
		q[2] = s[0]*e1[1] - s[1]*e1[0];
		det = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
		res.hit = 1'b0;
		res.distance = '0;
		thr = longint'(eps_reg) << (2*FB);
		adet = det < 0 ? -det : det;
		if (det == 0 || adet < thr)
			return res;
		uu = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
		vv = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
		tt = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
		if (det < 0) begin
			det = -det; uu = -uu; vv = -vv; tt = -tt;
		end
		if (uu < 0 || uu > det || vv < 0 || uu + vv > det)
			return res;
		res.hit = 1'b1;
		res.distance = div_q16(tt, det);
		return res;
	endfunction

	// Every result is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_hits.size() == 0) begin
				$display("%0t: unexpected result hit=%b distance=%h", $time,
					result.hit, result.distance);
				fail_count++;
			end else begin
				result_t want;
				want = expected_hits.pop_front();
				if (want.hit !== result.hit)
					$display("%0t: hit expected %b actual %b", $time, want.hit,
						result.hit);
				if (want.distance !== result.distance)
					$display("%0t: distance expected %h actual %h", $time,
						want.distance, result.distance);
				if (want !== result)
					fail_count++;
			end
		end
	end

	// Watchdog: fails the run after a long stretch with no ray accepted, no result and no configuration write.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_MAX) begin
			$display("tb_ray_triangle_intersection failed");
			$finish;
		end
	end

	int burst_left;

	// Sends one item, with bursts and random gaps between them. Start stays
	// high after the item so the next one in a burst follows with no gap.
	task automatic send_ray(ray_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		ray <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_hits.push_back(predict_intersection(r));
	endtask

	task automatic drain;
		start <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_VERTEX_ONE:   vert_a = val;
			REG_VERTEX_TWO:   vert_b = val;
			REG_VERTEX_THREE: vert_c = val;
			REG_EPSILON:      eps_reg = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [47:0] pack_vertex(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		ray_t r;
		r.origin_x = 16'(ox); r.origin_y = 16'(oy); r.origin_z = 16'(oz);
		r.direction_x = 16'(dx); r.direction_y = 16'(dy); r.direction_z = 16'(dz);
		return r;
	endfunction

	// Ray aimed at a random barycentric point of the triangle, sometimes
	// slightly outside it, from a random origin.
	function automatic ray_t aimed_ray(int spread);
		ray_t r;
		int   a, b, o[3], p[3], dd[3];
		a = $urandom_range(0, 300) - 20;
		b = $urandom_range(0, 300 - ((a > 0) ? a : 0)) - 20;
		for (int k = 0; k < 3; k++) begin
			p[k] = int'(coord(vert_a, k) + ((coord(vert_b, k) - coord(vert_a, k)) * a
				+ (coord(vert_c, k) - coord(vert_a, k)) * b) / 256);
			o[k] = $urandom_range(0, 2*spread) - spread;
			dd[k] = p[k] - o[k];
			if (dd[k] > 32767) dd[k] = 32767;
			if (dd[k] < -32768) dd[k] = -32768;
		end
		return make_ray(o[0], o[1], o[2], dd[0], dd[1], dd[2]);
	endfunction

	task automatic test_reset_triangle;
		// Rays toward the reset triangle, its vertices, edges and the plane.
		send_ray(make_ray(0, 0, 0, 85, 85, 85));
		send_ray(make_ray(0, 0, 0, 256, 0, 0));
		send_ray(make_ray(0, 0, 0, 128, 128, 0));
		send_ray(make_ray(0, 0, 0, -256, -256, -256));
		send_ray(make_ray(256, 256, 256, 85, 85, 85));
		send_ray(make_ray(0, 0, 0, 256, -256, 0));
		send_ray(make_ray(0, 0, 0, 0, 0, 0));
		send_ray(make_ray(-32768, -32768, -32768, 32767, 32767, 32767));
		send_ray(make_ray(32767, 32767, 32767, -32768, -32768, -32768));
		send_ray(make_ray(0, 0, 0, 1, 1, 1));
		send_ray(make_ray(-32768, 0, 0, 1, 0, 0));
		send_ray(make_ray(0, 0, 0, 256, 256, 256));
		drain();
	endtask

	task automatic test_extreme_triangle;
		write_reg(REG_VERTEX_ONE, pack_vertex(-32768, -32768, 0));
		write_reg(REG_VERTEX_TWO, pack_vertex(32767, -32768, 0));
		write_reg(REG_VERTEX_THREE, pack_vertex(0, 32767, 0));
		write_reg(REG_EPSILON, 48'd1);
		send_ray(make_ray(0, 0, 32767, 0, 0, -32768));
		send_ray(make_ray(0, 0, -32768, 0, 0, 1));
		send_ray(make_ray(0, 0, 256, 32767, 32767, 0));
		send_ray(make_ray(-32768, -32768, 32767, 0, 0, -1));
		drain();
		// Largest threshold turns almost every ray into a parallel miss.
		write_reg(REG_EPSILON, 48'hFFFF);
		send_ray(make_ray(0, 0, 32767, 0, 0, -32768));
		send_ray(make_ray(0, 0, 256, 0, 0, -1));
		drain();
	endtask

	task automatic test_random_rays;
		for (int phase = 0; phase < 6; phase++) begin
			int sz;
			sz = (phase == 0) ? 32767 : (256 << (phase % 4));
			write_reg(REG_VERTEX_ONE, {16'($urandom_range(0, 2*sz) - sz),
				16'($urandom_range(0, 2*sz) - sz), 16'($urandom_range(0, 2*sz) - sz)});
			write_reg(REG_VERTEX_TWO, (phase == 5) ? 48'({$urandom, $urandom})
				: {16'($urandom_range(0, 2*sz) - sz),
				16'($urandom_range(0, 2*sz) - sz), 16'($urandom_range(0, 2*sz) - sz)});
			write_reg(REG_VERTEX_THREE, {16'($urandom_range(0, 2*sz) - sz),
				16'($urandom_range(0, 2*sz) - sz), 16'($urandom_range(0, 2*sz) - sz)});
			write_reg(REG_EPSILON, (phase == 4) ? 48'($urandom)
				: 48'($urandom_range(1, 4)));
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				ray_t r;
				if ($urandom_range(0, 3) == 0)
					r = {$urandom, $urandom, $urandom};
				else
					r = aimed_ray(sz);
				send_ray(r);
				// Hold off once mid-phase until every result has come.
				if (i == 50) begin
					start <= 1'b0;
					while (expected_hits.size() != 0) @(posedge clk);
				end
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		ray = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		vert_a = VERTEX_ONE_RST;
		vert_b = VERTEX_TWO_RST;
		vert_c = VERTEX_THREE_RST;
		eps_reg = EPSILON_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_triangle();
		test_extreme_triangle();
		test_random_rays();
		drain();
		if (fail_count == 0)
			$display("tb_ray_triangle_intersection passed");
		else
			$display("tb_ray_triangle_intersection failed");
		$finish;
	end

endmodule
